// ----- src/ttre_pkg.sv -----
// ----------------------------------------------------------------------------
// ttre_pkg
// Shared widths, codes and types for the time tag record encoder.
// ----------------------------------------------------------------------------
package ttre_pkg;

  // default payload width of a record (the wrap period is 2^PAYLOAD_BITS ticks)
  localparam int PAYLOAD_BITS = 46;

  // default depth of the result queue, at least two
  localparam int QUEUE_DEPTH = 4;

  // fixed field widths
  localparam int TIME_W   = 63;
  localparam int RECORD_W = 48;
  localparam int STATUS_W = 2;
  localparam int PHOTON_W = 63;
  localparam int WRAP_W   = 17;
  localparam int TYPE_W   = 2;

  // record type codes, bits 1:0 of a record word
  localparam logic [TYPE_W-1:0] TYPE_PHOTON   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_OVERFLOW = 2'd1;

  // status codes carried beside each result
  localparam logic [STATUS_W-1:0] STATUS_PHOTON   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT   = 2'd2;

  // number of results pushed for one item
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  // one result item
  typedef struct packed {
    logic [WRAP_W-1:0]   wrap_total;
    logic [PHOTON_W-1:0] photon_total;
    logic                last_of_item;
    logic [STATUS_W-1:0] status;
    logic [RECORD_W-1:0] record_word;
  } result_t;

  // results of one item handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    second;
    result_t    first;
  } push_t;

endpackage

// ----- src/time_tag_record_encoder.sv -----
// ----------------------------------------------------------------------------
// time_tag_record_encoder
// Encodes absolute photon timestamps into 48-bit photon and overflow records.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one 63-bit timestamp per transfer. Output
//   stream m_axis carries one result per transfer: the record word, the
//   running photon and wrap totals in tdata, the status code in tuser, and
//   tlast on the final result belonging to an input transfer.
//   A timestamp below the last accepted one gives a single result with
//   status rejected and a zero record. A timestamp that crosses one or more
//   wrap boundaries gives an overflow record followed by its photon record.
//   Path: each timestamp is first captured in the input register, then its
//   results are written to the result queue, whose head drives m_axis; the
//   photon record behind an overflow record follows from the next slot.
//   Throughput: one input transfer per cycle; the output drains one result
//   per cycle, so overflow records are held in a result queue of
//   QUEUE_DEPTH entries, and s_axis_tready drops while the input register
//   holds a timestamp and that queue has no room for two results. A stalled
//   receiver therefore backs up into the input after the queue and the input
//   register fill.
//   Reset clears the wrap and photon counters, the last timestamp and the
//   queue; no results are pending afterwards.
// ----------------------------------------------------------------------------
module time_tag_record_encoder #(
  parameter int PAYLOAD_BITS = ttre_pkg::PAYLOAD_BITS,
  parameter int QUEUE_DEPTH  = ttre_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // time_stamp[62:0], zero bit 63
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // record_word[47:0], photon_total[110:48],
                                      // wrap_total[127:111]
  output logic         m_axis_tlast,  // last_of_item
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  ttre_pkg::push_t   push;
  logic              room;
  ttre_pkg::result_t head;

  // bookkeeping and record formation
  ttre_encode #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_encode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_time  (s_axis_tdata[ttre_pkg::TIME_W-1:0]),
    .room     (room),
    .push     (push)
  );

  // result queue towards the output stream
  ttre_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  // output packing
  assign m_axis_tdata = {head.wrap_total, head.photon_total, head.record_word};
  assign m_axis_tlast = head.last_of_item;
  assign m_axis_tuser = head.status;

endmodule

// ----- src/ttre_encode.sv -----
// ----------------------------------------------------------------------------
// ttre_encode
// Input register, wrap and photon bookkeeping, and record formation.
// ----------------------------------------------------------------------------
module ttre_encode #(
  parameter int PAYLOAD_BITS = ttre_pkg::PAYLOAD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ttre_pkg::TIME_W-1:0] in_time,
  input  logic                        room,
  output ttre_pkg::push_t             push
);

  localparam int HIGH_W = ttre_pkg::TIME_W - PAYLOAD_BITS;

  logic                          held;
  logic [ttre_pkg::TIME_W-1:0]   held_time;
  logic [ttre_pkg::TIME_W-1:0]   last_time;
  logic [ttre_pkg::WRAP_W-1:0]   wrap_count;
  logic [ttre_pkg::PHOTON_W-1:0] photon_count;

  logic                          fire;
  logic                          reject;
  logic [HIGH_W-1:0]             new_wraps;
  logic [63:0]                   wraps_wide;
  logic                          has_wraps;
  logic [ttre_pkg::WRAP_W-1:0]   wrap_count_next;
  logic [ttre_pkg::PHOTON_W-1:0] photon_count_next;
  logic [63:0]                   ovf_word;
  logic [63:0]                   pho_word;
  ttre_pkg::result_t             res_reject;
  ttre_pkg::result_t             res_ovf;
  ttre_pkg::result_t             res_pho;

  // the held item is processed once the queue has room for two results
  assign fire     = held && room;
  assign in_ready = !held || room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_time <= in_time;
    end
  end

  // wrap arithmetic on the high parts of the timestamps
  assign reject            = held_time < last_time;
  assign new_wraps         = held_time[ttre_pkg::TIME_W-1:PAYLOAD_BITS]
                           - last_time[ttre_pkg::TIME_W-1:PAYLOAD_BITS];
  assign wraps_wide        = 64'(new_wraps);
  assign has_wraps         = new_wraps != '0;
  assign wrap_count_next   = wrap_count + wraps_wide[ttre_pkg::WRAP_W-1:0];
  assign photon_count_next = photon_count + ttre_pkg::PHOTON_W'(1);

  // record words: payload above the type, cut to the record width
  assign ovf_word = 64'({wraps_wide[PAYLOAD_BITS-1:0], ttre_pkg::TYPE_OVERFLOW});
  assign pho_word = 64'({held_time[PAYLOAD_BITS-1:0], ttre_pkg::TYPE_PHOTON});

  always_comb begin
    res_reject.record_word  = '0;
    res_reject.status       = ttre_pkg::STATUS_REJECT;
    res_reject.last_of_item = 1'b1;
    res_reject.photon_total = photon_count;
    res_reject.wrap_total   = wrap_count;

    res_ovf.record_word  = ovf_word[ttre_pkg::RECORD_W-1:0];
    res_ovf.status       = ttre_pkg::STATUS_OVERFLOW;
    res_ovf.last_of_item = 1'b0;
    res_ovf.photon_total = photon_count;
    res_ovf.wrap_total   = wrap_count_next;

    res_pho.record_word  = pho_word[ttre_pkg::RECORD_W-1:0];
    res_pho.status       = ttre_pkg::STATUS_PHOTON;
    res_pho.last_of_item = 1'b1;
    res_pho.photon_total = photon_count_next;
    res_pho.wrap_total   = has_wraps ? wrap_count_next : wrap_count;
  end

  // results handed to the queue
  always_comb begin
    push.count  = ttre_pkg::PUSH_NONE;
    push.first  = res_pho;
    push.second = res_pho;
    if (fire) begin
      if (reject) begin
        push.count = ttre_pkg::PUSH_ONE;
        push.first = res_reject;
      end else if (has_wraps) begin
        push.count = ttre_pkg::PUSH_TWO;
        push.first = res_ovf;
      end else begin
        push.count = ttre_pkg::PUSH_ONE;
      end
    end
  end

  // encoder state, left alone by a rejected timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time    <= '0;
      wrap_count   <= '0;
      photon_count <= '0;
    end else if (fire && !reject) begin
      last_time    <= held_time;
      photon_count <= photon_count_next;
      if (has_wraps) begin
        wrap_count <= wrap_count_next;
      end
    end
  end

endmodule

// ----- src/ttre_result_queue.sv -----
// ----------------------------------------------------------------------------
// ttre_result_queue
// Small register queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module ttre_result_queue #(
  parameter int DEPTH = ttre_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ttre_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ttre_pkg::result_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttre_pkg::result_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  logic [PTR_W-1:0]  wr_ptr_inc;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic [CNT_W-1:0]  fill_next;
  logic              pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign room      = fill <= CNT_W'(DEPTH - 2);
  assign out_valid = fill != '0;
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // pointer and fill arithmetic
  always_comb begin
    wr_ptr_inc  = bump(wr_ptr);
    rd_ptr_next = pop ? bump(rd_ptr) : rd_ptr;
    case (push.count)
      ttre_pkg::PUSH_ONE: wr_ptr_next = wr_ptr_inc;
      ttre_pkg::PUSH_TWO: wr_ptr_next = bump(wr_ptr_inc);
      default:            wr_ptr_next = wr_ptr;
    endcase
    fill_next = fill + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // slot writes, the second result goes one slot further on
  always_ff @(posedge clk) begin
    if (push.count != ttre_pkg::PUSH_NONE) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == ttre_pkg::PUSH_TWO) begin
      slots[wr_ptr_inc] <= push.second;
    end
  end

endmodule

// ----- bench/ttre_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttre_checker
// Watches both streams of the time tag record encoder, works out the records
// each accepted timestamp should give, and compares every result transfer
// field by field against the oldest outstanding record.
// ----------------------------------------------------------------------------
module ttre_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // time_stamp[62:0], zero bit 63
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,   // record_word[47:0], photon_total[110:48],
                                       // wrap_total[127:111]
  input  logic         m_axis_tlast,   // last_of_item
  input  logic [1:0]   m_axis_tuser,   // status[1:0]
  output int           errors,
  output int           pending,
  output int           photon_records,
  output int           overflow_records,
  output int           rejected_stamps
);

  localparam int RECORD_W  = ttre_pkg::RECORD_W;
  localparam int PHOTON_W  = ttre_pkg::PHOTON_W;
  localparam int WRAP_W    = ttre_pkg::WRAP_W;
  localparam int TIME_W    = ttre_pkg::TIME_W;
  localparam int TYPE_W    = ttre_pkg::TYPE_W;
  localparam int PHOTON_LO = RECORD_W;
  localparam int WRAP_LO   = RECORD_W + PHOTON_W;
  localparam logic [TIME_W-1:0] PAYLOAD_MASK =
    TIME_W'((64'd1 << ttre_pkg::PAYLOAD_BITS) - 64'd1);

  // encoder state as the checker sees it
  logic [TIME_W-1:0]   seen_time;
  logic [WRAP_W-1:0]   wraps_seen;
  logic [PHOTON_W-1:0] photons_seen;

  // records still owed by the block, oldest first
  ttre_pkg::result_t records_due[$];

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t ns: mismatch in %s, got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // records owed for one accepted timestamp
  task automatic encode_stamp(input logic [TIME_W-1:0] stamp);
    ttre_pkg::result_t        rec;
    logic [TIME_W-1:0]        fresh_wraps;
    logic [TIME_W+TYPE_W-1:0] wide;
    rec = '0;
    if (stamp < seen_time) begin
      // stale timestamp: single zero record, state untouched
      rec.status       = ttre_pkg::STATUS_REJECT;
      rec.last_of_item = 1'b1;
      rec.photon_total = photons_seen;
      rec.wrap_total   = wraps_seen;
      records_due.push_back(rec);
      rejected_stamps++;
    end else begin
      fresh_wraps = (stamp >> ttre_pkg::PAYLOAD_BITS)
                  - (seen_time >> ttre_pkg::PAYLOAD_BITS);
      seen_time   = stamp;
      // overflow record ahead of the photon when wraps were crossed
      if (fresh_wraps != '0) begin
        wraps_seen       = wraps_seen + fresh_wraps[WRAP_W-1:0];
        wide             = {fresh_wraps & PAYLOAD_MASK, ttre_pkg::TYPE_OVERFLOW};
        rec.record_word  = wide[RECORD_W-1:0];
        rec.status       = ttre_pkg::STATUS_OVERFLOW;
        rec.last_of_item = 1'b0;
        rec.photon_total = photons_seen;
        rec.wrap_total   = wraps_seen;
        records_due.push_back(rec);
        overflow_records++;
      end
      photons_seen     = photons_seen + PHOTON_W'(1);
      wide             = {stamp & PAYLOAD_MASK, ttre_pkg::TYPE_PHOTON};
      rec.record_word  = wide[RECORD_W-1:0];
      rec.status       = ttre_pkg::STATUS_PHOTON;
      rec.last_of_item = 1'b1;
      rec.photon_total = photons_seen;
      rec.wrap_total   = wraps_seen;
      records_due.push_back(rec);
      photon_records++;
    end
  endtask

  // compare one result transfer with the oldest owed record
  task automatic check_result();
    ttre_pkg::result_t want;
    if (records_due.size() == 0) begin
      report("result with nothing pending", 64'(m_axis_tdata[RECORD_W-1:0]), '0);
    end else begin
      want = records_due.pop_front();
      if (m_axis_tdata[RECORD_W-1:0] !== want.record_word)
        report("record_word", 64'(m_axis_tdata[RECORD_W-1:0]), 64'(want.record_word));
      if (m_axis_tuser !== want.status)
        report("status", 64'(m_axis_tuser), 64'(want.status));
      if (m_axis_tlast !== want.last_of_item)
        report("last_of_item", 64'(m_axis_tlast), 64'(want.last_of_item));
      if (m_axis_tdata[PHOTON_LO +: PHOTON_W] !== want.photon_total)
        report("photon_total", 64'(m_axis_tdata[PHOTON_LO +: PHOTON_W]),
               64'(want.photon_total));
      if (m_axis_tdata[WRAP_LO +: WRAP_W] !== want.wrap_total)
        report("wrap_total", 64'(m_axis_tdata[WRAP_LO +: WRAP_W]),
               64'(want.wrap_total));
    end
  endtask

  // results are checked before the same edge's input is predicted
  always @(posedge clk) begin
    if (rst) begin
      seen_time        = '0;
      wraps_seen       = '0;
      photons_seen     = '0;
      errors           = 0;
      photon_records   = 0;
      overflow_records = 0;
      rejected_stamps  = 0;
      records_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result();
      if (s_axis_tvalid && s_axis_tready)
        encode_stamp(s_axis_tdata[TIME_W-1:0]);
    end
    pending = records_due.size();
  end

endmodule

// ----- bench/time_tag_record_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_tag_record_encoder_tb
// Feeds the encoder a walk of rising timestamps with equal stamps, wrap
// crossings, multi-wrap jumps and stale stamps mixed in, under random gaps on
// the input and random back-pressure on the output; ttre_checker judges the
// results and this module gives the verdict.
// ----------------------------------------------------------------------------
module time_tag_record_encoder_tb;

  localparam int          TIME_W        = ttre_pkg::TIME_W;
  localparam int          RANDOM_STAMPS = 1435;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          SETTLE_CYCLES = 20;
  localparam logic [63:0] TIME_MAX      = (64'd1 << TIME_W) - 64'd1;
  localparam logic [63:0] WRAP_SPAN     = 64'd1 << ttre_pkg::PAYLOAD_BITS;
  localparam logic [63:0] PAYLOAD_MASK  = WRAP_SPAN - 64'd1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  int errors, pending, photon_records, overflow_records, rejected_stamps;

  // stimulus bookkeeping
  logic [TIME_W-1:0] stamp_high = '0;
  int                stamps_sent = 0;
  bit                send_burst = 1'b0;
  int                idle_cycles = 0;

  always #5 clk = ~clk;

  time_tag_record_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  ttre_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .errors           (errors),
    .pending          (pending),
    .photon_records   (photon_records),
    .overflow_records (overflow_records),
    .rejected_stamps  (rejected_stamps)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // next timestamp of the walk: mostly forward, some stale
  function automatic logic [TIME_W-1:0] pick_stamp(input logic [TIME_W-1:0] high);
    logic [63:0] base, room, next_wrap, cand;
    int          sel;
    sel       = $urandom_range(0, 99);
    base      = {1'b0, high};
    room      = TIME_MAX - base;
    next_wrap = ((base >> ttre_pkg::PAYLOAD_BITS) + 64'd1) << ttre_pkg::PAYLOAD_BITS;
    if (sel >= 90 && high != '0)
      cand = rand64() % base;
    else if (sel < 55)
      cand = base + 64'($urandom_range(0, 65535));
    else if (sel < 63)
      cand = base;
    else if (sel < 75)
      cand = next_wrap | (rand64() & PAYLOAD_MASK);
    else if (sel < 85)
      cand = base + rand64() % (room / 64'd32 + 64'd1);
    else
      cand = $urandom_range(0, 1) ? next_wrap : next_wrap - 64'd1;
    if (cand > TIME_MAX)
      cand = TIME_MAX;
    return cand[TIME_W-1:0];
  endfunction

  // one input transfer after a random gap
  task automatic send_stamp(input logic [TIME_W-1:0] stamp);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, stamp};
    do @(posedge clk); while (!s_axis_tready);
    if (stamp >= stamp_high)
      stamp_high = stamp;
    stamps_sent++;
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: equal stamps, payload extremes, exact boundaries, stale stamps
    send_stamp('0);
    send_stamp('0);
    send_stamp(TIME_W'(WRAP_SPAN - 64'd1));
    send_stamp(TIME_W'(WRAP_SPAN - 64'd2));
    send_stamp('0);
    send_stamp(TIME_W'(WRAP_SPAN));
    send_stamp(TIME_W'(WRAP_SPAN));
    send_stamp(TIME_W'(64'd3 * WRAP_SPAN + 64'd5));
    send_stamp(TIME_W'(64'd3 * WRAP_SPAN + 64'd4));
    send_stamp(TIME_W'((64'd1 << 50) + WRAP_SPAN - 64'd1));

    // random walk towards the top of the time axis
    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      if (i % 60 == 0)
        send_burst = ($urandom_range(0, 3) == 0);
      send_stamp(pick_stamp(stamp_high));
    end
    send_burst = 1'b0;

    // directed: last wrap, largest stamp, stale stamps at the top
    send_stamp(TIME_W'(TIME_MAX & ~PAYLOAD_MASK));
    send_stamp(TIME_W'(TIME_MAX));
    send_stamp(TIME_W'(TIME_MAX));
    send_stamp(TIME_W'(TIME_MAX - 64'd1));
    send_stamp('0);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d timestamps, top stamp %0h", stamps_sent, stamp_high);
    $display("records checked: %0d photon, %0d overflow, %0d rejected",
             photon_records, overflow_records, rejected_stamps);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // receiver back-pressure, with stall-free stretches
  initial begin
    int stall;
    int taken;
    bit recv_burst;
    taken      = 0;
    recv_burst = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 50 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
